### sv/dsf_pkg.sv
// Shared types and constants for the disk sector framer with CRC-16.
// Depends on nothing; every module of the framer imports it.
package dsf_pkg;

  // Sector geometry and record constants
  localparam int unsigned SECTOR_BYTES = 256;
  localparam int unsigned BL_W         = $clog2(SECTOR_BYTES + 1);
  localparam logic [7:0]  SCRAMBLE_KEY = 8'hB3;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;

  // Queue depths between front and back, and at the result side
  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned OUT_DEPTH = 4;

  typedef struct packed {
    logic       mode;
    logic [7:0] track;
    logic [7:0] sector;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       record_end;
  } out_item_t;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_DATA  = 1'b1
  } cmd_kind_e;

  // b0 is track or data byte, b1 is sector; last marks the closing data byte
  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] b0;
    logic [7:0] b1;
    logic       last;
  } cmd_t;

  typedef enum logic [2:0] {
    PH_CMD,
    PH_HDR1,
    PH_HDR2,
    PH_HDR3,
    PH_CRC_HI,
    PH_CRC_LO
  } phase_e;

endpackage

### sv/dsf_front.sv
// Front end of the sector framer: accepts items, tracks the open sector and
// turns each item into a command for the back end. Depends on dsf_pkg.
module dsf_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  dsf_pkg::in_item_t item_i,
  output logic              cmd_push_o,
  output dsf_pkg::cmd_t     cmd_o
);
  import dsf_pkg::*;

  logic            in_sector_q, in_sector_d;
  logic [BL_W-1:0] bytes_left_q, bytes_left_d;

  // Classify the accepted item; drop data that falls outside a sector
  always_comb begin
    in_sector_d  = in_sector_q;
    bytes_left_d = bytes_left_q;
    cmd_push_o   = 1'b0;
    cmd_o.kind   = CMD_DATA;
    cmd_o.b0     = item_i.data_byte;
    cmd_o.b1     = item_i.sector;
    cmd_o.last   = (bytes_left_q == BL_W'(1));
    if (accept_i) begin
      if (item_i.mode == 1'b0) begin
        cmd_push_o   = 1'b1;
        cmd_o.kind   = CMD_START;
        cmd_o.b0     = item_i.track;
        cmd_o.last   = 1'b0;
        bytes_left_d = BL_W'(SECTOR_BYTES);
        in_sector_d  = 1'b1;
      end else if (in_sector_q) begin
        cmd_push_o   = 1'b1;
        bytes_left_d = bytes_left_q - BL_W'(1);
        if (cmd_o.last) begin
          in_sector_d = 1'b0;
        end
      end
    end
  end

  // Hold sector state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_sector_q  <= 1'b0;
      bytes_left_q <= '0;
    end else begin
      in_sector_q  <= in_sector_d;
      bytes_left_q <= bytes_left_d;
    end
  end

  // A closed sector has no bytes outstanding
  a_closed_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_sector_q |-> bytes_left_q == '0)
    else $error("closed sector with bytes left");

  // Every open sector still expects at least one byte
  a_open_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_sector_q |-> bytes_left_q != '0)
    else $error("open sector with no bytes left");

  // The last command of a sector closes it
  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_push_o && cmd_o.kind == CMD_DATA && cmd_o.last) |=> !in_sector_q)
    else $error("sector left open after last byte");

endmodule

### sv/dsf_cmd_queue.sv
// Short command queue that decouples the framer front end from the back end.
// Depends on dsf_pkg for the command type and depth.
module dsf_cmd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dsf_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output dsf_pkg::cmd_t cmd_o,
  output logic          empty_o
);
  import dsf_pkg::*;

  localparam int unsigned AW = $clog2(CMD_DEPTH);
  localparam int unsigned CW = $clog2(CMD_DEPTH + 1);

  cmd_t          mem_q [CMD_DEPTH];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(CMD_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    cnt_d = cnt_q + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store pushed commands
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CMD_DEPTH))
    else $error("command queue overfilled");

  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> cnt_q == $past(cnt_q) + CW'(1))
    else $error("command count lost a push");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == CW'(CMD_DEPTH)) |-> wr_ptr_q == rd_ptr_q)
    else $error("queue pointers out of step with count");

endmodule

### sv/dsf_back.sv
// Back end of the sector framer: runs commands through the CRC-16 unit,
// sequences header and trailer bytes and queues results. Depends on dsf_pkg.
module dsf_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_empty_i,
  input  dsf_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  output logic               empty_o,
  input  logic               pop_i,
  output dsf_pkg::out_item_t out_item_o
);
  import dsf_pkg::*;

  localparam int unsigned AW = $clog2(OUT_DEPTH);
  localparam int unsigned CW = $clog2(OUT_DEPTH + 1);

  // One reflected CRC-16 nibble step, polynomial 0x8408
  function automatic logic [15:0] nib_tab(input logic [3:0] idx);
    logic [15:0] t;
    unique case (idx)
      4'h0: t = 16'h0000;  4'h1: t = 16'h1081;
      4'h2: t = 16'h2102;  4'h3: t = 16'h3183;
      4'h4: t = 16'h4204;  4'h5: t = 16'h5285;
      4'h6: t = 16'h6306;  4'h7: t = 16'h7387;
      4'h8: t = 16'h8408;  4'h9: t = 16'h9489;
      4'hA: t = 16'ha50a;  4'hB: t = 16'hb58b;
      4'hC: t = 16'hc60c;  4'hD: t = 16'hd68d;
      4'hE: t = 16'he70e;  4'hF: t = 16'hf78f;
      default: t = 16'h0000;
    endcase
    return t;
  endfunction

  function automatic logic [15:0] crc_nib(input logic [15:0] acc, input logic [3:0] nib);
    return {4'h0, acc[15:4]} ^ nib_tab(acc[3:0] ^ nib);
  endfunction

  // Low nibble first, then high nibble
  function automatic logic [15:0] crc_byte(input logic [15:0] acc, input logic [7:0] b);
    return crc_nib(crc_nib(acc, b[3:0]), b[7:4]);
  endfunction

  phase_e        phase_q, phase_d;
  logic [15:0]   crc_q, crc_d;
  logic [7:0]    trk_q, trk_d, sec_q, sec_d;
  logic          emit, can_emit;
  out_item_t     emit_item;

  out_item_t     mem_q [OUT_DEPTH];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_pop;

  assign can_emit   = (cnt_q != CW'(OUT_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign do_pop     = pop_i && !empty_o;
  assign out_item_o = mem_q[rd_ptr_q];

  // Sequence commands, header and trailer bytes
  always_comb begin
    phase_d   = phase_q;
    crc_d     = crc_q;
    trk_d     = trk_q;
    sec_d     = sec_q;
    emit      = 1'b0;
    emit_item = '0;
    cmd_pop_o = 1'b0;
    if (can_emit) begin
      unique case (phase_q)
        PH_CMD: begin
          if (!cmd_empty_i) begin
            cmd_pop_o = 1'b1;
            emit      = 1'b1;
            unique case (cmd_i.kind)
              CMD_START: begin
                emit_item = '{out_byte: 8'h00, record_end: 1'b0};
                crc_d     = crc_byte(CRC_INIT, 8'h00);
                trk_d     = cmd_i.b0;
                sec_d     = cmd_i.b1;
                phase_d   = PH_HDR1;
              end
              CMD_DATA: begin
                emit_item = '{out_byte: cmd_i.b0 ^ SCRAMBLE_KEY, record_end: 1'b0};
                crc_d     = crc_byte(crc_q, cmd_i.b0);
                if (cmd_i.last) begin
                  phase_d = PH_CRC_HI;
                end
              end
              default: ;
            endcase
          end
        end
        PH_HDR1: begin
          emit      = 1'b1;
          emit_item = '{out_byte: 8'h00, record_end: 1'b0};
          crc_d     = crc_byte(crc_q, 8'h00);
          phase_d   = PH_HDR2;
        end
        PH_HDR2: begin
          emit      = 1'b1;
          emit_item = '{out_byte: trk_q, record_end: 1'b0};
          crc_d     = crc_byte(crc_q, trk_q);
          phase_d   = PH_HDR3;
        end
        PH_HDR3: begin
          emit      = 1'b1;
          emit_item = '{out_byte: sec_q, record_end: 1'b0};
          crc_d     = crc_byte(crc_q, sec_q);
          phase_d   = PH_CMD;
        end
        PH_CRC_HI: begin
          emit      = 1'b1;
          emit_item = '{out_byte: crc_q[15:8], record_end: 1'b0};
          phase_d   = PH_CRC_LO;
        end
        PH_CRC_LO: begin
          emit      = 1'b1;
          emit_item = '{out_byte: crc_q[7:0], record_end: 1'b1};
          phase_d   = PH_CMD;
        end
        default: phase_d = PH_CMD;
      endcase
    end
  end

  // Advance result queue pointers
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (emit) begin
      wr_ptr_d = (wr_ptr_q == AW'(OUT_DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(OUT_DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    cnt_d = cnt_q + CW'(emit) - CW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_CMD;
      crc_q    <= CRC_INIT;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      crc_q    <= crc_d;
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Hold header bytes and queued results
  always_ff @(posedge clk_i) begin
    trk_q <= trk_d;
    sec_q <= sec_d;
    if (emit) begin
      mem_q[wr_ptr_q] <= emit_item;
    end
  end

  a_emit_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> can_emit)
    else $error("result pushed into a full queue");

  a_end_only_lo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && emit_item.record_end) |-> phase_q == PH_CRC_LO)
    else $error("record end outside the CRC low byte");

  a_hi_then_lo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && phase_q == PH_CRC_HI) |=> phase_q == PH_CRC_LO)
    else $error("CRC high byte not followed by low byte");

  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> (phase_q == PH_CMD && !cmd_empty_i))
    else $error("command taken while a sequence runs");

endmodule

### sv/disk_sector_framer_crc16.sv
// Top level of the disk sector framer with reflected CRC-16 (0x8408).
// Depends on dsf_pkg, dsf_front, dsf_cmd_queue and dsf_back.
//
//   channel  | handshake        | payload
//   ---------+------------------+---------------------------------------
//   input    | push / full      | in_item_i  : mode, track, sector, data
//   result   | empty / pop      | out_item_o : out_byte, record_end
//
// Data items are taken one per cycle while full is low; the back end writes
// one result byte per cycle while the result queue has room, so a start item
// yields four result bytes and a closing data byte three. A result passes
// the command queue, then the result queue. Reset clears control state only.
// full rises when header and trailer cycles or a stalled result side back
// up the command queue.
module disk_sector_framer_crc16 (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  dsf_pkg::in_item_t  in_item_i,
  output logic               empty,
  input  logic               pop,
  output dsf_pkg::out_item_t out_item_o
);
  import dsf_pkg::*;

  logic accept;
  logic cmd_push, cmd_pop, cmd_empty;
  cmd_t cmd_in, cmd_out;

  assign accept = push && !full;

  dsf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (in_item_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  dsf_cmd_queue u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .cmd_o   (cmd_out),
    .empty_o (cmd_empty)
  );

  dsf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .out_item_o  (out_item_o)
  );

endmodule
